// ===== rtl/bld_pkg.sv =====
// Shared types and codes for the bounded list deque with search.
`timescale 1ns / 1ps

package bld_pkg;

    // Request modes carried on the mode field.
    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_DELETE     = 3'd4,
        MODE_FIND       = 3'd5
    } t_mode;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Memory write operations of the datapath.
    typedef enum logic [2:0] {
        WR_NONE = 3'd0,
        WR_TAIL = 3'd1,
        WR_HEAD = 3'd2,
        WR_UP   = 3'd3,
        WR_DN   = 3'd4
    } t_wr_op;

    // Entry count updates.
    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_INC  = 2'd1,
        CNT_DEC  = 2'd2
    } t_cnt_op;

    // Start values for the walking index.
    typedef enum logic [1:0] {
        IDX_ZERO   = 2'd0,
        IDX_ONE    = 2'd1,
        IDX_LAST   = 2'd2,
        IDX_POS_P1 = 2'd3
    } t_idx_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load_key;
        logic     rd_en;
        logic     idx_load;
        t_idx_sel idx_sel;
        logic     idx_inc;
        logic     idx_dec;
        t_wr_op   wr_op;
        t_cnt_op  cnt_op;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic one;
        logic rvalid;
        logic match;
        logic rd_last;
        logic rd_first;
    } t_dp_stat;

endpackage

// ===== rtl/bld_datapath.sv =====
// Datapath: entry memory, entry count, search key and the walking index.
`timescale 1ns / 1ps

module bld_datapath
    import bld_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic signed [31:0] i_value,
    output t_dp_stat           o_stat,
    output logic [4:0]         o_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0]   mem [DEPTH];
    logic [31:0]   r_key;
    logic [31:0]   r_rdata;
    logic          r_rvalid;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] n_idx;
    logic [CW-1:0] r_rd_idx;
    logic [CW-1:0] idx_init;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] waddr;
    logic [31:0]   wdata;
    logic          we;

    assign cnt_m1 = r_cnt - CW'(1);

    // Start value of the walking index.
    always_comb begin
        unique case (i_cmd.idx_sel)
            IDX_ZERO:   idx_init = '0;
            IDX_ONE:    idx_init = CW'(1);
            IDX_LAST:   idx_init = cnt_m1;
            IDX_POS_P1: idx_init = r_rd_idx + CW'(1);
            default:    idx_init = '0;
        endcase
    end

    // Walking index: load, step up or step down.
    always_comb begin
        priority if (i_cmd.idx_load) begin
            n_idx = idx_init;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + CW'(1);
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - CW'(1);
        end else begin
            n_idx = r_idx;
        end
    end

    // Entry count update.
    always_comb begin
        unique case (i_cmd.cnt_op)
            CNT_HOLD: n_cnt = r_cnt;
            CNT_INC:  n_cnt = r_cnt + CW'(1);
            CNT_DEC:  n_cnt = cnt_m1;
            default:  n_cnt = r_cnt;
        endcase
    end

    // Write port: new ends come from the key, shifted words from the read data.
    always_comb begin
        we    = 1'b1;
        waddr = '0;
        wdata = r_key;
        unique case (i_cmd.wr_op)
            WR_NONE: we = 1'b0;
            WR_TAIL: waddr = r_cnt;
            WR_HEAD: waddr = '0;
            WR_UP: begin
                waddr = r_rd_idx + CW'(1);
                wdata = r_rdata;
            end
            WR_DN: begin
                waddr = r_rd_idx - CW'(1);
                wdata = r_rdata;
            end
            default: we = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_rvalid <= 1'b0;
            r_idx    <= '0;
            r_rd_idx <= '0;
        end else begin
            r_cnt    <= n_cnt;
            r_rvalid <= i_cmd.rd_en;
            r_idx    <= n_idx;
            if (i_cmd.rd_en) begin
                r_rd_idx <= r_idx;
            end
        end
    end

    // Key register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_key <= i_value;
        end
    end

    // Entry memory with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr[AW-1:0]] <= wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[r_idx[AW-1:0]];
        end
    end

    // Status towards the controller.
    assign o_stat.empty    = (r_cnt == '0);
    assign o_stat.full     = (r_cnt == CW'(DEPTH));
    assign o_stat.one      = (r_cnt == CW'(1));
    assign o_stat.rvalid   = r_rvalid;
    assign o_stat.match    = r_rvalid && (r_rdata == r_key);
    assign o_stat.rd_last  = (r_rd_idx == cnt_m1);
    assign o_stat.rd_first = (r_rd_idx == '0);

    assign o_count = 5'(r_cnt);

endmodule

// ===== rtl/bld_ctrl.sv =====
// Controller: sequences each request over the datapath and forms the result flags.
`timescale 1ns / 1ps

module bld_ctrl
    import bld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_mode,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy,
    output logic       o_done,
    output logic       o_found,
    output logic [1:0] o_status
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_SEARCH = 7'b0000100,
        S_SHDN   = 7'b0001000,
        S_SHUP   = 7'b0010000,
        S_HEAD   = 7'b0100000,
        S_DONE   = 7'b1000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_mode   r_mode;
    t_mode   n_mode;
    logic    r_found;
    logic    n_found;
    t_status r_status;
    t_status n_status;

    // Next state and datapath commands.
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_found  = r_found;
        n_status = r_status;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_key = 1'b1;
                    n_mode         = t_mode'(i_mode);
                    n_found        = 1'b0;
                    n_status       = ST_OK;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (r_mode)
                    MODE_PUSH_FRONT: begin
                        if (i_stat.full) begin
                            n_status = ST_FULL;
                        end else if (i_stat.empty) begin
                            o_cmd.wr_op  = WR_HEAD;
                            o_cmd.cnt_op = CNT_INC;
                        end else begin
                            o_cmd.idx_load = 1'b1;
                            o_cmd.idx_sel  = IDX_LAST;
                            n_state        = S_SHUP;
                        end
                    end
                    MODE_PUSH_BACK: begin
                        if (i_stat.full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_cmd.wr_op  = WR_TAIL;
                            o_cmd.cnt_op = CNT_INC;
                        end
                    end
                    MODE_POP_FRONT: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                        end else if (i_stat.one) begin
                            o_cmd.cnt_op = CNT_DEC;
                        end else begin
                            o_cmd.idx_load = 1'b1;
                            o_cmd.idx_sel  = IDX_ONE;
                            n_state        = S_SHDN;
                        end
                    end
                    MODE_POP_BACK: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_cmd.cnt_op = CNT_DEC;
                        end
                    end
                    MODE_DELETE: begin
                        if (i_stat.empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            o_cmd.idx_load = 1'b1;
                            o_cmd.idx_sel  = IDX_ZERO;
                            n_state        = S_SEARCH;
                        end
                    end
                    MODE_FIND: begin
                        if (!i_stat.empty) begin
                            o_cmd.idx_load = 1'b1;
                            o_cmd.idx_sel  = IDX_ZERO;
                            n_state        = S_SEARCH;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SEARCH: begin
                // Reads run one entry ahead of the compare.
                o_cmd.rd_en   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.match) begin
                    o_cmd.rd_en = 1'b0;
                    n_found     = 1'b1;
                    n_state     = S_DONE;
                    if (r_mode == MODE_DELETE) begin
                        if (i_stat.rd_last) begin
                            o_cmd.cnt_op = CNT_DEC;
                        end else begin
                            o_cmd.idx_load = 1'b1;
                            o_cmd.idx_sel  = IDX_POS_P1;
                            n_state        = S_SHDN;
                        end
                    end
                end else if (i_stat.rvalid && i_stat.rd_last) begin
                    o_cmd.rd_en = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_SHDN: begin
                // Move each later entry one place towards the head.
                o_cmd.rd_en   = 1'b1;
                o_cmd.idx_inc = 1'b1;
                if (i_stat.rvalid) begin
                    o_cmd.wr_op = WR_DN;
                    if (i_stat.rd_last) begin
                        o_cmd.rd_en  = 1'b0;
                        o_cmd.cnt_op = CNT_DEC;
                        n_state      = S_DONE;
                    end
                end
            end
            S_SHUP: begin
                // Move every entry one place towards the tail, last one first.
                o_cmd.rd_en   = 1'b1;
                o_cmd.idx_dec = 1'b1;
                if (i_stat.rvalid) begin
                    o_cmd.wr_op = WR_UP;
                    if (i_stat.rd_first) begin
                        o_cmd.rd_en = 1'b0;
                        n_state     = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                o_cmd.wr_op  = WR_HEAD;
                o_cmd.cnt_op = CNT_INC;
                n_state      = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and result flag registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_PUSH_FRONT;
            r_found  <= 1'b0;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_found  = r_found;
    assign o_status = r_status;

endmodule

// ===== rtl/bounded_list_deque_with_search.sv =====
// Top level of the bounded list deque with search: controller, datapath and checks.
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit words, position 0 at the head.
// A request (i_mode, i_value) is taken at a rising edge with start high and
// busy low; busy then stays high until the result has been shown. The result
// (o_found, o_status, o_count) is on the ports for exactly one cycle, marked
// by o_done, and must be taken then: the receiver cannot hold it off.
// Push back, pop back, pop front of a single word, and a request that is
// rejected or finds the list empty complete without walking the memory.
// Pop front and push front into a non-empty list shift the held words one
// place; find and delete search from the head, and a delete hit before the
// last word closes the gap by shifting the later words towards the head.
// The entry memory has one write and one registered read port; searching
// and shifting stream through it at one word per cycle. The next request is
// taken at the earliest at the end of the cycle after the strobe.
// Reset (synchronous, active low) empties the list and returns to idle;
// the memory contents are not cleared and are never read before written.

module bounded_list_deque_with_search
    import bld_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_value,
    output logic               o_done,
    output logic               o_found,
    output logic [1:0]         o_status,
    output logic [4:0]         o_count
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer.
    bld_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_stat   (dp_stat),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_found  (o_found),
        .o_status (o_status)
    );

    // Storage and compare.
    bld_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_value (i_value),
        .o_stat  (dp_stat),
        .o_count (o_count)
    );

    // A result word is shown for one cycle only.
    a_done_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // The block goes idle only straight after showing a result.
    a_idle_after_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> $past(o_done))
        else $error("busy dropped without a result");

    // A push is rejected only when the list really holds DEPTH words.
    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == ST_FULL) |-> (o_count == 5'(DEPTH)))
        else $error("full status with a list that is not full");

    // A hit is never reported together with an empty or full status.
    a_found_ok : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_found |-> (o_status == ST_OK))
        else $error("found flagged with a non-ok status");

endmodule

// ===== verif/tb_bounded_list_deque_with_search.sv =====
// Self-checking testbench for the bounded list deque with search.
`timescale 1ns / 1ps

module tb_bounded_list_deque_with_search;
    import bld_pkg::*;

    localparam int          DEPTH        = 16;
    localparam int          RANDOM_WORDS = 1100;
    localparam int          CALM_WORDS   = 150;
    localparam int          DRAIN_CYCLES = 2 * DEPTH + 20;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [2:0]  MODE_SPARE_6 = 3'd6;
    localparam logic [2:0]  MODE_SPARE_7 = 3'd7;
    localparam logic [31:0] VAL_MIN      = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_ABSENT   = 32'h5A5A_5A5A;

    // One expected result word.
    typedef struct {
        logic       found;
        t_status    status;
        logic [4:0] count;
    } t_deque_result;

    // Keeps its own copy of the list and the results still to come.
    class t_deque_scoreboard;
        logic [31:0]   held[$];
        t_deque_result awaited[$];
        int            mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function logic [31:0] pick_held();
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

        // Applies an accepted request word to the list and queues its result.
        function void note_request(logic [2:0] mode, logic [31:0] value);
            t_deque_result res;
            int            pos;
            res.found  = 1'b0;
            res.status = ST_OK;
            pos        = -1;
            for (int i = 0; i < held.size(); i++) begin
                if (pos < 0 && held[i] == value) begin
                    pos = i;
                end
            end
            case (mode)
                MODE_PUSH_FRONT: begin
                    if (held.size() >= DEPTH) res.status = ST_FULL;
                    else held.push_front(value);
                end
                MODE_PUSH_BACK: begin
                    if (held.size() >= DEPTH) res.status = ST_FULL;
                    else held.push_back(value);
                end
                MODE_POP_FRONT: begin
                    if (held.size() == 0) res.status = ST_EMPTY;
                    else void'(held.pop_front());
                end
                MODE_POP_BACK: begin
                    if (held.size() == 0) res.status = ST_EMPTY;
                    else void'(held.pop_back());
                end
                MODE_DELETE: begin
                    if (held.size() == 0) begin
                        res.status = ST_EMPTY;
                    end else if (pos >= 0) begin
                        held.delete(pos);
                        res.found = 1'b1;
                    end
                end
                MODE_FIND: begin
                    res.found = (pos >= 0);
                end
                default: begin
                end
            endcase
            res.count = 5'(held.size());
            awaited.push_back(res);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compares a result word with the oldest expectation.
        task check_result(logic found, logic [1:0] status, logic [4:0] count);
            t_deque_result exp;
            if (awaited.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                exp = awaited.pop_front();
                if (found !== exp.found)
                    report_mismatch($sformatf("found %b, expected %b", found, exp.found));
                if (status !== exp.status)
                    report_mismatch($sformatf("status %0d, expected %0d", status, exp.status));
                if (count !== exp.count)
                    report_mismatch($sformatf("count %0d, expected %0d", count, exp.count));
            end
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         i_mode;
    logic signed [31:0] i_value;
    logic               o_done;
    logic               o_found;
    logic [1:0]         o_status;
    logic [4:0]         o_count;

    t_deque_scoreboard sb = new();
    bit                idle_on = 1'b1;
    int                cycle_count = 0;

    bounded_list_deque_with_search #(.DEPTH(DEPTH)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_mode   (i_mode),
        .i_value  (i_value),
        .o_done   (o_done),
        .o_found  (o_found),
        .o_status (o_status),
        .o_count  (o_count)
    );

    // Clock generation.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result words are taken at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_found, o_status, o_count);
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_bounded_list_deque_with_search NOT OK");
            $finish;
        end
    end

    // Presents one request word, waits for it to be taken, then maybe idles.
    task automatic issue_word(input logic [2:0] mode, input logic [31:0] value);
        int gap;
        start   <= 1'b1;
        i_mode  <= mode;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        sb.note_request(mode, value);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Keys favour values already held and a few corner values, so that finds
    // and deletes hit often and duplicates occur.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4 && sb.held.size() != 0) return sb.pick_held();
        if (r < 7) begin
            case ($urandom_range(0, 7))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return 32'hFFFF_FFFF;
                3: return VAL_ABSENT;
                default: return $urandom_range(0, 3);
            endcase
        end
        return $urandom;
    endfunction

    // Stimulus: reset, directed words, then random words in phases.
    initial begin
        logic [2:0] mode;
        int         push_bias;
        int         r;
        start    <= 1'b0;
        i_mode   <= MODE_PUSH_FRONT;
        i_value  <= '0;
        i_rst_n  <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        @(posedge i_clk);

        // Find, pop and delete on an empty list.
        issue_word(MODE_FIND, '0);
        issue_word(MODE_POP_FRONT, '0);
        issue_word(MODE_POP_BACK, '0);
        issue_word(MODE_DELETE, VAL_MIN);
        // Fill to the bound from both ends, extremes included.
        issue_word(MODE_PUSH_BACK, VAL_MAX);
        issue_word(MODE_PUSH_FRONT, VAL_MIN);
        issue_word(MODE_PUSH_BACK, '0);
        issue_word(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        for (int i = 4; i < DEPTH; i++) begin
            issue_word((i % 2) ? MODE_PUSH_FRONT : MODE_PUSH_BACK, $urandom);
        end
        // Pushes into a full list are rejected.
        issue_word(MODE_PUSH_FRONT, 32'h1);
        issue_word(MODE_PUSH_BACK, 32'h2);
        // Search and removal, hit and miss, and the unused modes.
        issue_word(MODE_FIND, VAL_MAX);
        issue_word(MODE_FIND, VAL_ABSENT);
        issue_word(MODE_DELETE, VAL_MIN);
        issue_word(MODE_DELETE, VAL_ABSENT);
        issue_word(MODE_SPARE_6, VAL_MAX);
        issue_word(MODE_SPARE_7, VAL_MIN);
        issue_word(MODE_POP_FRONT, '0);
        issue_word(MODE_POP_BACK, '0);

        // Random words; the push bias swings so the list runs full and empty.
        push_bias = 50;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 80 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_bias = 75;
                    1: push_bias = 25;
                    default: push_bias = 50;
                endcase
            end
            if (n % 40 == 0) idle_on = ($urandom_range(0, 9) < 6);
            if (n >= RANDOM_WORDS - CALM_WORDS) idle_on = 1'b0;
            r = $urandom_range(0, 99);
            if (r == 0) begin
                mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
            end else if (r <= push_bias) begin
                mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
            end else begin
                case ($urandom_range(0, 3))
                    0: mode = MODE_POP_FRONT;
                    1: mode = MODE_POP_BACK;
                    2: mode = MODE_DELETE;
                    default: mode = MODE_FIND;
                endcase
            end
            issue_word(mode, pick_value());
        end
        start <= 1'b0;

        // Drain the outstanding results, then allow for stray strobes.
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("tb_bounded_list_deque_with_search OK");
        end else begin
            $display("tb_bounded_list_deque_with_search NOT OK");
        end
        $finish;
    end

endmodule
